@@ hdl/u8dec_pkg.sv @@
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types, constants and helper functions of the utf-8 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8dec_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int LEN_W   = 3;
    localparam int PCNT_W  = 2;

    // result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int MAX_RES     = 3;
    localparam int NRES_W      = 2;

    // sequence length codes, zero means no sequence open
    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // one queued result
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            run_end;
    } out_entry_t;

    // sequence length implied by a lead byte, LEN_NONE when no pattern fits
    function automatic logic [LEN_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] len;
        if ((b & 8'h80) == 8'h00)
            len = LEN_ONE;
        else if ((b & 8'hE0) == 8'hC0)
            len = LEN_TWO;
        else if ((b & 8'hF0) == 8'hE0)
            len = LEN_THREE;
        else if ((b & 8'hF8) == 8'hF0)
            len = LEN_FOUR;
        else
            len = LEN_NONE;
        return len;
    endfunction

    // a byte decoded as a text on its own
    function automatic logic [CP_W-1:0] single_cp(input logic [BYTE_W-1:0] b);
        logic [CP_W-1:0] cp;
        if (lead_len(b) == LEN_ONE)
            cp = {13'd0, b};
        else
            cp = REPLACEMENT_CP;
        return cp;
    endfunction

    // two byte sequence
    function automatic logic [CP_W-1:0] assemble2(input logic [BYTE_W-1:0] b0,
                                                  input logic [BYTE_W-1:0] b1);
        return {10'd0, b0[4:0], b1[5:0]};
    endfunction

endpackage

`default_nettype wire

@@ hdl/u8dec_in_if.sv @@
// ----------------------------------------------------------------------------
// u8dec_in_if
// Byte channel into the decoder: valid/ready handshake with byte payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8dec_in_if;
    logic                           valid;
    logic                           ready;
    logic [u8dec_pkg::BYTE_W-1:0]   text_byte;
    logic                           final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/u8dec_out_if.sv @@
// ----------------------------------------------------------------------------
// u8dec_out_if
// Code point channel out of the decoder: valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8dec_out_if;
    logic                           valid;
    logic                           ready;
    logic [u8dec_pkg::CP_W-1:0]     code_point;
    logic                           run_end;

    modport source (output valid, output code_point, output run_end, input ready);
    modport sink   (input valid, input code_point, input run_end, output ready);
endinterface

`default_nettype wire

@@ hdl/utf8_codepoint_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_unit
// Streaming utf-8 decoder: one byte per transaction in, code points out.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                     | handshake
//  ---------+-----+-----------------------------+-------------
//  text     | in  | text_byte[7:0], final_byte  | valid/ready
//  points   | out | code_point[20:0], run_end   | valid/ready
//
//  A byte is decoded in the cycle it is accepted and its results (0 to 3)
//  land in a four-entry result queue, whose registered head drives points.
//  With points.ready high one byte is taken every cycle; only a final
//  byte that truncates a sequence yields two or three results, which
//  drain one per cycle and hold off text until one entry is left.
//  text.ready is high while the queue holds at most one entry.
//  Reset closes any open sequence and empties the queue.
//
`default_nettype none

module utf8_codepoint_decoder_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    u8dec_in_if.sink    text,
    u8dec_out_if.source points
);

    // decoder state
    logic [u8dec_pkg::LEN_W-1:0]    seq_len_reg, seq_len_next;
    logic [u8dec_pkg::PCNT_W-1:0]   pend_cnt_reg, pend_cnt_next;
    logic [u8dec_pkg::BYTE_W-1:0]   pend_reg [3];
    logic                           pend_we;
    logic [u8dec_pkg::PCNT_W-1:0]   pend_widx;

    // result queue
    u8dec_pkg::out_entry_t          q_reg [u8dec_pkg::QUEUE_DEPTH];
    u8dec_pkg::out_entry_t          q_next [u8dec_pkg::QUEUE_DEPTH];
    logic [u8dec_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;

    // per-byte results
    logic [u8dec_pkg::CP_W-1:0]     res_cp [u8dec_pkg::MAX_RES];
    logic [u8dec_pkg::NRES_W-1:0]   nres;
    logic [u8dec_pkg::PCNT_W:0]     n_held;
    logic [u8dec_pkg::LEN_W-1:0]    len_in;
    logic [u8dec_pkg::LEN_W-1:0]    len_b1;
    logic [u8dec_pkg::CP_W-1:0]     asm_cp;

    logic                           acc;
    logic                           pop;
    logic [u8dec_pkg::BYTE_W-1:0]   b;

    assign acc = text.valid && text.ready;
    assign pop = points.valid && points.ready;
    assign b   = text.text_byte;

    // handshake outputs
    assign text.ready        = (cnt_reg <= 3'd1);
    assign points.valid      = (cnt_reg != 3'd0);
    assign points.code_point = q_reg[0].code_point;
    assign points.run_end    = q_reg[0].run_end;

    // open sequence completed by this byte
    always_comb
    begin
        case (seq_len_reg)
            u8dec_pkg::LEN_TWO:
                asm_cp = u8dec_pkg::assemble2(pend_reg[0], b);
            u8dec_pkg::LEN_THREE:
                asm_cp = {5'd0, pend_reg[0][3:0], pend_reg[1][5:0], b[5:0]};
            u8dec_pkg::LEN_FOUR:
                asm_cp = {pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0], b[5:0]};
            default:
                asm_cp = {13'd0, pend_reg[0]};
        endcase
    end

    // byte decode
    always_comb
    begin
        len_in        = u8dec_pkg::lead_len(b);
        len_b1        = u8dec_pkg::lead_len(pend_reg[1]);
        n_held        = {1'b0, pend_cnt_reg} + 3'd1;
        nres          = 2'd0;
        res_cp[0]     = u8dec_pkg::REPLACEMENT_CP;
        res_cp[1]     = u8dec_pkg::REPLACEMENT_CP;
        res_cp[2]     = u8dec_pkg::REPLACEMENT_CP;
        seq_len_next  = seq_len_reg;
        pend_cnt_next = pend_cnt_reg;
        pend_we       = 1'b0;
        pend_widx     = pend_cnt_reg;

        if (seq_len_reg == u8dec_pkg::LEN_NONE)
        begin
            if (len_in == u8dec_pkg::LEN_ONE)
            begin
                res_cp[0] = {13'd0, b};
                nres      = 2'd1;
            end
            else if (len_in == u8dec_pkg::LEN_NONE || text.final_byte)
            begin
                nres = 2'd1;
            end
            else
            begin
                pend_we       = 1'b1;
                pend_widx     = 2'd0;
                pend_cnt_next = 2'd1;
                seq_len_next  = len_in;
            end
        end
        else if (n_held >= seq_len_reg)
        begin
            res_cp[0]     = asm_cp;
            nres          = 2'd1;
            seq_len_next  = u8dec_pkg::LEN_NONE;
            pend_cnt_next = 2'd0;
        end
        else if (text.final_byte)
        begin
            // truncated: lead gives the replacement, the rest decoded anew
            if (pend_cnt_reg == 2'd1)
            begin
                res_cp[1] = u8dec_pkg::single_cp(b);
                nres      = 2'd2;
            end
            else if (len_b1 == u8dec_pkg::LEN_ONE)
            begin
                res_cp[1] = {13'd0, pend_reg[1]};
                res_cp[2] = u8dec_pkg::single_cp(b);
                nres      = 2'd3;
            end
            else if (len_b1 == u8dec_pkg::LEN_TWO)
            begin
                res_cp[1] = u8dec_pkg::assemble2(pend_reg[1], b);
                nres      = 2'd2;
            end
            else
            begin
                res_cp[2] = u8dec_pkg::single_cp(b);
                nres      = 2'd3;
            end
            seq_len_next  = u8dec_pkg::LEN_NONE;
            pend_cnt_next = 2'd0;
        end
        else
        begin
            pend_we       = 1'b1;
            pend_cnt_next = n_held[u8dec_pkg::PCNT_W-1:0];
        end

        if (text.final_byte)
        begin
            seq_len_next  = u8dec_pkg::LEN_NONE;
            pend_cnt_next = 2'd0;
        end
    end

    // result queue update: pop from the head, append this byte's results
    always_comb
    begin
        logic [u8dec_pkg::QCNT_W-1:0] base;
        logic [u8dec_pkg::QCNT_W-1:0] widx;
        base = cnt_reg - {2'd0, pop};
        widx = base;
        for (int i = 0; i < u8dec_pkg::QUEUE_DEPTH - 1; i++)
        begin
            if (pop)
                q_next[i] = q_reg[i+1];
            else
                q_next[i] = q_reg[i];
        end
        q_next[u8dec_pkg::QUEUE_DEPTH-1] = q_reg[u8dec_pkg::QUEUE_DEPTH-1];
        cnt_next = base;
        if (acc)
        begin
            for (int j = 0; j < u8dec_pkg::MAX_RES; j++)
            begin
                widx = base + 3'(j);
                if (2'(j) < nres)
                begin
                    q_next[widx[u8dec_pkg::QIDX_W-1:0]].code_point = res_cp[j];
                    q_next[widx[u8dec_pkg::QIDX_W-1:0]].run_end    = (nres == 2'(j + 1));
                end
            end
            cnt_next = base + {1'b0, nres};
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg  <= u8dec_pkg::LEN_NONE;
            pend_cnt_reg <= 2'd0;
            cnt_reg      <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (acc)
            begin
                seq_len_reg  <= seq_len_next;
                pend_cnt_reg <= pend_cnt_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (acc && pend_we)
            pend_reg[pend_widx] <= b;
        for (int i = 0; i < u8dec_pkg::QUEUE_DEPTH; i++)
            q_reg[i] <= q_next[i];
    end

    // checks
    logic last_end;
    always_comb
    begin
        case (cnt_reg)
            3'd1:    last_end = q_reg[0].run_end;
            3'd2:    last_end = q_reg[1].run_end;
            3'd3:    last_end = q_reg[2].run_end;
            3'd4:    last_end = q_reg[3].run_end;
            default: last_end = 1'b1;
        endcase
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("result queue overfilled");

    a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && text.final_byte) |=> (seq_len_reg == u8dec_pkg::LEN_NONE))
        else $error("sequence left open after final byte");

    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_len_reg != u8dec_pkg::LEN_NONE) |->
            (pend_cnt_reg != 2'd0 && {1'b0, pend_cnt_reg} < seq_len_reg))
        else $error("held byte count inconsistent with sequence length");

    a_tail_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 3'd0) |-> last_end)
        else $error("queue tail lacks run_end");

endmodule

`default_nettype wire

@@ sim/utf8_codepoint_decoder_unit_test.sv @@
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_unit_test
// Self-checking bench for the streaming utf-8 decoder. A directed table of
// bytes covers range extremes, bad leads, surrogates and texts that end
// inside a sequence. Its rows carry hand-written results where they are
// obvious, and every other row uses the bench's own decoder model. A
// random mix of well-formed sequences, cut-off sequences and noise bytes
// follows. Both channels idle at random, and the output side holds off for
// a long stretch so that the input stalls.
// ----------------------------------------------------------------------------

module utf8_codepoint_decoder_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    localparam int N_DIRECTED   = 25;
    localparam int RANDOM_ITEMS = 155;
    localparam int IDLE_PCT     = 36;
    localparam int CALM_FROM    = 200;
    localparam int CALM_TO      = 300;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_LEN     = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int QUIET_LIMIT  = 2000;

    // one row of stimulus, with hand-written results where known is set
    typedef struct packed {
        logic [u8dec_pkg::BYTE_W-1:0] text_byte;
        logic                         final_byte;
        logic                         known;
        logic [1:0]                   n_known;
        logic [u8dec_pkg::CP_W-1:0]   first_cp;
        logic [u8dec_pkg::CP_W-1:0]   second_cp;
    } stim_row_t;

    // directed rows: extremes, bad leads, surrogate, max code point, cut-off texts
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b1, 2'd1, 21'h000000, 21'd0},
        '{8'h7F, 1'b0, 1'b1, 2'd1, 21'h00007F, 21'd0},
        '{8'h80, 1'b0, 1'b1, 2'd1, u8dec_pkg::REPLACEMENT_CP, 21'd0},
        '{8'hFF, 1'b0, 1'b1, 2'd1, u8dec_pkg::REPLACEMENT_CP, 21'd0},
        '{8'hC2, 1'b0, 1'b1, 2'd0, 21'd0, 21'd0},
        '{8'hA9, 1'b0, 1'b0, 2'd0, 21'd0, 21'd0},
        '{8'hDF, 1'b0, 1'b0, 2'd0, 21'd0, 21'd0},
        '{8'hBF, 1'b0, 1'b0, 2'd0, 21'd0, 21'd0},
        '{8'hED, 1'b0, 1'b0, 2'd0, 21'd0, 21'd0},
        '{8'hA0, 1'b0, 1'b0, 2'd0, 21'd0, 21'd0},
        '{8'h80, 1'b0, 1'b0, 2'd0, 21'd0, 21'd0},
        '{8'hF7, 1'b0, 1'b0, 2'd0, 21'd0, 21'd0},
        '{8'hBF, 1'b0, 1'b0, 2'd0, 21'd0, 21'd0},
        '{8'hBF, 1'b0, 1'b0, 2'd0, 21'd0, 21'd0},
        '{8'hBF, 1'b0, 1'b0, 2'd0, 21'd0, 21'd0},
        '{8'hC2, 1'b1, 1'b1, 2'd1, u8dec_pkg::REPLACEMENT_CP, 21'd0},
        '{8'h41, 1'b1, 1'b1, 2'd1, 21'h000041, 21'd0},
        '{8'hE2, 1'b0, 1'b0, 2'd0, 21'd0, 21'd0},
        '{8'h82, 1'b1, 1'b1, 2'd2, u8dec_pkg::REPLACEMENT_CP, u8dec_pkg::REPLACEMENT_CP},
        '{8'hF0, 1'b0, 1'b0, 2'd0, 21'd0, 21'd0},
        '{8'h41, 1'b0, 1'b0, 2'd0, 21'd0, 21'd0},
        '{8'hC3, 1'b1, 1'b0, 2'd0, 21'd0, 21'd0},
        '{8'hF0, 1'b0, 1'b0, 2'd0, 21'd0, 21'd0},
        '{8'hC3, 1'b0, 1'b0, 2'd0, 21'd0, 21'd0},
        '{8'hA9, 1'b1, 1'b0, 2'd0, 21'd0, 21'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    u8dec_in_if  text_ch ();
    u8dec_out_if point_ch ();

    utf8_codepoint_decoder_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .points (point_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    stim_row_t             text_items [$];
    u8dec_pkg::out_entry_t expected_points [$];
    u8dec_pkg::out_entry_t fresh_points [$];
    int                    bytes_taken = 0;
    int                    faults = 0;

    // decoder model state
    logic [2:0][u8dec_pkg::BYTE_W-1:0] held = '0;
    int                                held_count = 0;
    logic [u8dec_pkg::LEN_W-1:0]       open_len = u8dec_pkg::LEN_NONE;

    // sequence length announced by a lead byte
    function automatic logic [u8dec_pkg::LEN_W-1:0] seq_len(
        input logic [u8dec_pkg::BYTE_W-1:0] b);
        case (b) inside
            8'b0???????: return u8dec_pkg::LEN_ONE;
            8'b110?????: return u8dec_pkg::LEN_TWO;
            8'b1110????: return u8dec_pkg::LEN_THREE;
            8'b11110???: return u8dec_pkg::LEN_FOUR;
            default:     return u8dec_pkg::LEN_NONE;
        endcase
    endfunction

    // code point of a complete sequence starting at s[start]
    function automatic logic [u8dec_pkg::CP_W-1:0] join_seq(
        input logic [3:0][u8dec_pkg::BYTE_W-1:0] s, input int start, input int len);
        logic [u8dec_pkg::CP_W-1:0] acc;
        case (len)
            2:       acc = u8dec_pkg::CP_W'(s[start][4:0]);
            3:       acc = u8dec_pkg::CP_W'(s[start][3:0]);
            4:       acc = u8dec_pkg::CP_W'(s[start][2:0]);
            default: acc = u8dec_pkg::CP_W'(s[start]);
        endcase
        for (int i = 1; i < len; i++)
            acc = (acc << 6) | u8dec_pkg::CP_W'(s[start + i][5:0]);
        return acc;
    endfunction

    function automatic void add_point(input logic [u8dec_pkg::CP_W-1:0] cp);
        u8dec_pkg::out_entry_t e;
        e.code_point = cp;
        e.run_end    = 1'b0;
        fresh_points.insert(fresh_points.size(), e);
    endfunction

    // model of one byte transaction; results land in fresh_points
    function automatic void decode_byte(input logic [u8dec_pkg::BYTE_W-1:0] b,
                                        input logic fin);
        logic [3:0][u8dec_pkg::BYTE_W-1:0] s;
        logic [u8dec_pkg::LEN_W-1:0]       len;
        int                                n;
        int                                pos;
        fresh_points.delete();
        s = '0;
        if (open_len == u8dec_pkg::LEN_NONE)
        begin
            len = seq_len(b);
            if (len == u8dec_pkg::LEN_ONE)
                add_point(u8dec_pkg::CP_W'(b));
            else if (len == u8dec_pkg::LEN_NONE || fin)
                add_point(u8dec_pkg::REPLACEMENT_CP);
            else
            begin
                held[0]    = b;
                held_count = 1;
                open_len   = len;
            end
        end
        else
        begin
            n = held_count;
            for (int i = 0; i < n; i++)
                s[i] = held[i];
            s[n] = b;
            n++;
            if (n >= open_len)
            begin
                add_point(join_seq(s, 0, open_len));
                held_count = 0;
                open_len   = u8dec_pkg::LEN_NONE;
            end
            else if (fin)
            begin
                // text ends inside a sequence: re-decode the tail as a short text
                pos = 0;
                while (pos < n)
                begin
                    len = seq_len(s[pos]);
                    if (len == u8dec_pkg::LEN_ONE)
                    begin
                        add_point(u8dec_pkg::CP_W'(s[pos]));
                        pos++;
                    end
                    else if (len != u8dec_pkg::LEN_NONE && pos + len <= n)
                    begin
                        add_point(join_seq(s, pos, len));
                        pos += len;
                    end
                    else
                    begin
                        add_point(u8dec_pkg::REPLACEMENT_CP);
                        pos++;
                    end
                end
            end
            else
            begin
                held[n - 1] = b;
                held_count  = n;
            end
        end
        if (fin)
        begin
            held_count = 0;
            open_len   = u8dec_pkg::LEN_NONE;
        end
        if (fresh_points.size() > 0)
            fresh_points[fresh_points.size() - 1].run_end = 1'b1;
    endfunction

    function automatic void add_item(input logic [u8dec_pkg::BYTE_W-1:0] b,
                                     input logic fin);
        stim_row_t r;
        r            = '0;
        r.text_byte  = b;
        r.final_byte = fin;
        text_items.insert(text_items.size(), r);
    endfunction

    // random idle decision, none inside the calm window
    function automatic logic take_break(input int cyc);
        if (cyc >= CALM_FROM && cyc < CALM_TO)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // check results against the oldest expectation, then model accepted bytes
    always @(posedge clk)
    begin : scoreboard
        u8dec_pkg::out_entry_t want;
        stim_row_t             row;
        u8dec_pkg::out_entry_t e;
        if (rst_n)
        begin
            if (point_ch.valid && point_ch.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("unexpected result: code_point %h run_end %b",
                           point_ch.code_point, point_ch.run_end);
                    faults++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (point_ch.code_point !== want.code_point)
                    begin
                        $error("code_point: expected %h, actual %h",
                               want.code_point, point_ch.code_point);
                        faults++;
                    end
                    if (point_ch.run_end !== want.run_end)
                    begin
                        $error("run_end: expected %b, actual %b",
                               want.run_end, point_ch.run_end);
                        faults++;
                    end
                end
            end
            if (text_ch.valid && text_ch.ready)
            begin
                row = text_items[bytes_taken];
                bytes_taken++;
                decode_byte(text_ch.text_byte, text_ch.final_byte);
                if (row.known)
                begin
                    for (int i = 0; i < row.n_known; i++)
                    begin
                        e.code_point = (i == 0) ? row.first_cp : row.second_cp;
                        e.run_end    = (i == row.n_known - 1);
                        expected_points.insert(expected_points.size(), e);
                    end
                end
                else
                begin
                    foreach (fresh_points[i])
                        expected_points.insert(expected_points.size(), fresh_points[i]);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if (!rst_n || (text_ch.valid && text_ch.ready) ||
            (point_ch.valid && point_ch.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("utf8_codepoint_decoder_unit_test: done, errors");
            $finish;
        end
    end

    // output side: random stalls plus one long hold-off
    initial
    begin : point_sink
        int cyc;
        int hold;
        cyc  = 0;
        hold = 0;
        point_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                cyc++;
                if (cyc == HOLD_AT)
                    hold = HOLD_LEN;
                if (hold > 0)
                begin
                    hold--;
                    point_ch.ready <= 1'b0;
                end
                else
                    point_ch.ready <= !take_break(cyc);
            end
        end
    end

    // stimulus build, reset, byte transactions and end of run
    initial
    begin : main
        int                           idx;
        int                           cyc;
        int                           pick;
        int                           seq_bytes;
        int                           keep;
        logic                         ends;
        logic [u8dec_pkg::BYTE_W-1:0] b;

        rst_n = 1'b0;
        text_ch.valid      <= 1'b0;
        text_ch.text_byte  <= '0;
        text_ch.final_byte <= 1'b0;

        for (int i = 0; i < N_DIRECTED; i++)
            text_items.insert(text_items.size(), DIRECTED_ROWS[i]);

        // random part: mostly well-formed sequences, some cut short, some noise
        while (text_items.size() < N_DIRECTED + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
            begin
                seq_bytes = $urandom_range(1, 4);
                keep      = seq_bytes;
                if (seq_bytes > 1 && $urandom_range(0, 99) < 20)
                    keep = $urandom_range(1, seq_bytes - 1);
                if (keep < seq_bytes)
                    ends = $urandom_range(0, 99) < 70;
                else
                    ends = $urandom_range(0, 99) < 10;
                for (int j = 0; j < keep; j++)
                begin
                    if (j == 0)
                    begin
                        case (seq_bytes)
                            1:       b = {1'b0, 7'($urandom)};
                            2:       b = {3'b110, 5'($urandom)};
                            3:       b = {4'b1110, 4'($urandom)};
                            default: b = {5'b11110, 3'($urandom)};
                        endcase
                    end
                    else
                        b = {2'b10, 6'($urandom)};
                    add_item(b, ends && j == keep - 1);
                end
            end
            else
                add_item(8'($urandom), $urandom_range(0, 99) < 15);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // byte sender: hold an offer until taken, idle at random between offers
        idx = 0;
        cyc = 0;
        while (idx < text_items.size())
        begin
            @(posedge clk);
            cyc++;
            if (text_ch.valid && text_ch.ready)
                idx++;
            if (!(text_ch.valid && !text_ch.ready))
            begin
                if (idx < text_items.size() && !take_break(cyc))
                begin
                    text_ch.valid      <= 1'b1;
                    text_ch.text_byte  <= text_items[idx].text_byte;
                    text_ch.final_byte <= text_items[idx].final_byte;
                end
                else
                    text_ch.valid <= 1'b0;
            end
        end

        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (faults == 0)
            $display("utf8_codepoint_decoder_unit_test: done, clean");
        else
            $display("utf8_codepoint_decoder_unit_test: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/u8dec_pkg.sv
hdl/u8dec_in_if.sv
hdl/u8dec_out_if.sv
hdl/utf8_codepoint_decoder_unit.sv
sim/utf8_codepoint_decoder_unit_test.sv
